/* rtl/dcnor_pkg.sv */
// Shared types and constants of the depth column nearest object range block.
`default_nettype none

package dcnor_pkg;

	// Width of a range in unsigned Q16.8 millimetres.
	localparam int RANGE_W = 24;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] CFG_CORRECTION    = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SIMILAR_ABOVE = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SIMILAR_BELOW = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_CONTACTS  = 8'd3;
	localparam int CFG_DATA_W = 17;

	// Configuration register reset values.
	localparam logic [15:0] CORRECTION_RESET    = 16'd939;
	localparam logic [16:0] SIMILAR_ABOVE_RESET = 17'd67502;
	localparam logic [16:0] SIMILAR_BELOW_RESET = 17'd63627;
	localparam logic [7:0]  MIN_CONTACTS_RESET  = 8'd5;

	// Result status codes.
	localparam logic [1:0] STATUS_UNKNOWN = 2'd0;
	localparam logic [1:0] STATUS_VALID   = 2'd1;
	localparam logic [1:0] STATUS_CLEAR   = 2'd2;

	// Reported range of a clear angle, and the output saturation limit.
	localparam logic [12:0] CLEAR_RANGE_MM = 13'd5000;
	localparam logic [12:0] RANGE_OUT_MAX  = 13'd8191;

	// The sentinel range is twice the maximum range of 4000 mm times the upper ratio.
	localparam logic [12:0] SENTINEL_MM = 13'd8000;
	localparam logic [RANGE_W-1:0] SENTINEL_RESET =
		RANGE_W'((64'(SENTINEL_MM) * 64'(SIMILAR_ABOVE_RESET)) >> 8);

	// Status of the shared divider.
	typedef struct packed {
		logic busy;
		logic done;
	} dcnor_div_stat_t;

endpackage

`default_nettype wire

/* rtl/dcnor_div.sv */
// Restoring radix-2 divider of a range difference by the cluster count.
`default_nettype none

module dcnor_div
	import dcnor_pkg::*;
#(
	parameter int DEN_W = 9
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [RANGE_W-1:0]   dividend,
	input  wire logic [DEN_W-1:0]     divisor,
	output dcnor_div_stat_t           stat,
	output logic [RANGE_W-1:0]        quotient
);

	localparam int STEP_W = $clog2(RANGE_W);

	logic [DEN_W-1:0]   rem_q;
	logic [DEN_W-1:0]   den_q;
	logic [RANGE_W-1:0] quo_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic               done_q;
	logic [DEN_W:0]     trial;
	logic               fits;

	// One quotient bit per cycle: the dividend shifts out at the top of quo_q
	// while quotient bits shift in at the bottom.
	assign trial = {rem_q, quo_q[RANGE_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(RANGE_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DEN_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[DEN_W-1:0];
			end
			quo_q <= {quo_q[RANGE_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

`default_nettype wire

/* rtl/depth_column_nearest_object_range.sv */
// Top level of the depth column nearest object range block.
`default_nettype none

// The block reduces the depth samples of one scan angle to the range of the
// nearest object. Samples arrive one transaction at a time with their own
// thresholds and range factor; the transaction with last_point set closes the
// angle and yields exactly one result transaction, after which the block starts
// a fresh angle with the current configuration. A sample that is ignored, that
// marks the angle clear, or that is zero does not start the contact sequence. A
// sample that becomes a contact runs a sequencer around one shared 33 by 17 bit
// multiplier (square, correction, scaling and the two similarity products), and
// a sample that joins the current cluster goes on to the radix-2 divider that
// updates the running mean. Closing an angle adds the sentinel product, then the
// result, and the result waits in an output register until it is taken. The
// input is not ready while an item is being worked on. Configuration writes
// are always accepted and must only be issued while the block is idle.
module depth_column_nearest_object_range
	import dcnor_pkg::*;
#(
	parameter int MAX_POINTS = 256
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Configuration write channel.
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	// Sample channel.
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [15:0]            depth_mm,
	input  wire logic [15:0]            out_of_band_mm,
	input  wire logic [15:0]            free_space_mm,
	input  wire logic [15:0]            range_factor_q14,
	input  wire logic                   last_point,
	// Result channel.
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [12:0]                 range_mm,
	output logic [1:0]                  status
);

	// The cluster count saturates at the lesser of MAX_POINTS and 511.
	localparam int COUNT_CAP = (MAX_POINTS < 511) ? MAX_POINTS : 511;
	localparam int COUNT_W   = $clog2(COUNT_CAP + 1);
	localparam int CMP_W     = (COUNT_W > 8) ? COUNT_W : 8;

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b0000_0000_0001,
		ST_SQUARE = 12'b0000_0000_0010,
		ST_COEF   = 12'b0000_0000_0100,
		ST_SUM    = 12'b0000_0000_1000,
		ST_SCALE  = 12'b0000_0001_0000,
		ST_SAT    = 12'b0000_0010_0000,
		ST_BELOW  = 12'b0000_0100_0000,
		ST_ABOVE  = 12'b0000_1000_0000,
		ST_DECIDE = 12'b0001_0000_0000,
		ST_DIVIDE = 12'b0010_0000_0000,
		ST_SENT   = 12'b0100_0000_0000,
		ST_REPORT = 12'b1000_0000_0000
	} dcnor_state_t;

	dcnor_state_t state_q, state_d;

	// Configuration registers.
	logic [15:0] correction_q;
	logic [16:0] similar_above_q;
	logic [16:0] similar_below_q;
	logic [7:0]  min_contacts_q;

	// Per-angle state.
	logic [RANGE_W-1:0] range_q;
	logic [COUNT_W-1:0] count_q;
	logic               seen_in_q;
	logic               seen_past_q;

	// Working registers of the current sample.
	logic [15:0]        depth_q;
	logic [15:0]        factor_q;
	logic               last_q;
	logic [32:0]        corr_q;
	logic [49:0]        prod_q;
	logic [RANGE_W-1:0] sample_q;
	logic               nearer_q;
	logic               up_q;

	// Result register.
	logic               out_valid_q;
	logic [12:0]        range_mm_q;
	logic [1:0]         status_q;

	// Shared multiplier.
	logic [32:0] mul_a;
	logic [16:0] mul_b;
	logic        mul_en;
	logic [49:0] mul_p;

	logic               in_take;
	logic               in_past;
	logic               in_contact;
	logic               out_free;
	logic               joins;
	logic [COUNT_W-1:0] count_next;
	logic [RANGE_W-1:0] diff;
	logic [32:0]        corr_next;
	logic [48:0]        sq_round;
	logic [49:0]        scale_round;
	logic [35:0]        scale_full;
	logic [RANGE_W-1:0] sample_next;
	logic [RANGE_W:0]   out_round;
	logic [12:0]        res_range;
	logic [1:0]         res_status;
	logic               div_start;
	dcnor_div_stat_t    div_stat;
	logic [RANGE_W-1:0] div_quo;
	dcnor_state_t       item_end;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_take   = in_valid && in_ready;

	// A sample above the out-of-band depth is dropped, one above the free-space
	// depth marks the angle clear, and any other nonzero sample is a contact.
	assign in_past    = (depth_mm <= out_of_band_mm) && (depth_mm > free_space_mm);
	assign in_contact = (depth_mm <= out_of_band_mm) && (depth_mm <= free_space_mm)
		&& (depth_mm != 16'd0);

	assign out_free = !out_valid_q || out_ready;
	assign item_end = last_q ? ST_SENT : ST_IDLE;

	// Corrected depth in Q.8 mm: d * 256 plus the rounded quadratic term.
	assign sq_round  = {1'b0, prod_q[47:0]} + 49'd32768;
	assign corr_next = sq_round[48:16] + {9'd0, depth_q, 8'd0};

	// Horizontal range in Q16.8 mm, rounded and saturated to 24 bits.
	assign scale_round = prod_q + 50'd8192;
	assign scale_full  = scale_round[49:14];
	assign sample_next = (|scale_full[35:RANGE_W]) ? {RANGE_W{1'b1}} : scale_full[RANGE_W-1:0];

	// The product register holds similar_above times the running range here.
	assign joins = {1'b0, sample_q, 16'd0} < prod_q[40:0];

	assign count_next = (count_q < COUNT_W'(COUNT_CAP)) ? count_q + COUNT_W'(1) : count_q;
	assign diff       = (sample_q >= range_q) ? sample_q - range_q : range_q - sample_q;
	assign div_start  = (state_q == ST_DECIDE) && !nearer_q && joins;

	dcnor_div #(
		.DEN_W (COUNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (diff),
		.divisor  (count_next),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// The mean rounds half up to whole millimetres and saturates at 8191.
	assign out_round = {1'b0, range_q} + (RANGE_W + 1)'(128);

	always_comb begin
		res_range  = 13'd0;
		res_status = STATUS_UNKNOWN;
		if (seen_in_q) begin
			if (CMP_W'(count_q) >= CMP_W'(min_contacts_q)) begin
				res_range  = (|out_round[RANGE_W:21]) ? RANGE_OUT_MAX : out_round[20:8];
				res_status = STATUS_VALID;
			end
		end else if (seen_past_q) begin
			res_range  = CLEAR_RANGE_MM;
			res_status = STATUS_CLEAR;
		end
	end

	// Operand selection of the shared multiplier for each sequencer step.
	always_comb begin
		mul_a  = 33'd0;
		mul_b  = 17'd0;
		mul_en = 1'b0;
		case (state_q)
			ST_SQUARE: begin
				mul_a  = {17'd0, depth_q};
				mul_b  = {1'b0, depth_q};
				mul_en = 1'b1;
			end
			ST_COEF: begin
				mul_a  = {1'b0, prod_q[31:0]};
				mul_b  = {1'b0, correction_q};
				mul_en = 1'b1;
			end
			ST_SCALE: begin
				mul_a  = corr_q;
				mul_b  = {1'b0, factor_q};
				mul_en = 1'b1;
			end
			ST_BELOW: begin
				mul_a  = {9'd0, range_q};
				mul_b  = similar_below_q;
				mul_en = 1'b1;
			end
			ST_ABOVE: begin
				mul_a  = {9'd0, range_q};
				mul_b  = similar_above_q;
				mul_en = 1'b1;
			end
			ST_SENT: begin
				mul_a  = {20'd0, SENTINEL_MM};
				mul_b  = similar_above_q;
				mul_en = 1'b1;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_contact) begin
						state_d = ST_SQUARE;
					end else if (last_point) begin
						state_d = ST_SENT;
					end
				end
			end
			ST_SQUARE: state_d = ST_COEF;
			ST_COEF:   state_d = ST_SUM;
			ST_SUM:    state_d = ST_SCALE;
			ST_SCALE:  state_d = ST_SAT;
			ST_SAT:    state_d = ST_BELOW;
			ST_BELOW:  state_d = ST_ABOVE;
			ST_ABOVE:  state_d = ST_DECIDE;
			ST_DECIDE: begin
				state_d = div_start ? ST_DIVIDE : item_end;
			end
			ST_DIVIDE: begin
				if (div_stat.done) begin
					state_d = item_end;
				end
			end
			ST_SENT:   state_d = ST_REPORT;
			ST_REPORT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Control state, configuration and the per-angle cluster state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			correction_q    <= CORRECTION_RESET;
			similar_above_q <= SIMILAR_ABOVE_RESET;
			similar_below_q <= SIMILAR_BELOW_RESET;
			min_contacts_q  <= MIN_CONTACTS_RESET;
			range_q         <= SENTINEL_RESET;
			count_q         <= '0;
			seen_in_q       <= 1'b0;
			seen_past_q     <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CORRECTION:    correction_q    <= cfg_data[15:0];
					CFG_SIMILAR_ABOVE: similar_above_q <= cfg_data;
					CFG_SIMILAR_BELOW: similar_below_q <= cfg_data;
					CFG_MIN_CONTACTS:  min_contacts_q  <= cfg_data[7:0];
					default: begin
					end
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_past) begin
						seen_past_q <= 1'b1;
					end
				end
				ST_DECIDE: begin
					// A clearly nearer sample restarts the cluster; one within the
					// similarity band joins it and goes on to the mean update.
					seen_in_q <= 1'b1;
					if (nearer_q) begin
						count_q <= COUNT_W'(1);
						range_q <= sample_q;
					end else if (joins) begin
						count_q <= count_next;
					end
				end
				ST_DIVIDE: begin
					if (div_stat.done) begin
						range_q <= up_q ? range_q + div_quo : range_q - div_quo;
					end
				end
				ST_REPORT: begin
					// The result is latched and the angle starts over with the
					// sentinel that the previous step left in the product register.
					if (out_free) begin
						range_q     <= prod_q[RANGE_W+7:8];
						count_q     <= '0;
						seen_in_q   <= 1'b0;
						seen_past_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase

			if ((state_q == ST_REPORT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Sample and arithmetic registers.
	always_ff @(posedge clk) begin
		if (in_take) begin
			depth_q  <= depth_mm;
			factor_q <= range_factor_q14;
			last_q   <= last_point;
		end
		if (mul_en) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_SUM) begin
			corr_q <= corr_next;
		end
		if (state_q == ST_SAT) begin
			sample_q <= sample_next;
		end
		if (state_q == ST_ABOVE) begin
			// The product register holds similar_below times the running range here.
			nearer_q <= {1'b0, sample_q, 16'd0} < prod_q[40:0];
		end
		if (state_q == ST_DECIDE) begin
			up_q <= sample_q >= range_q;
		end
		if ((state_q == ST_REPORT) && out_free) begin
			range_mm_q <= res_range;
			status_q   <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign range_mm  = range_mm_q;
	assign status    = status_q;

`ifndef ASSERT_OFF
	// The divider is running or has just finished whenever the sequencer waits on it.
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE) |-> (div_stat.busy || div_stat.done))
		else $error("sequencer waits on an idle divider");

	// A cluster can only have members after an in-range sample.
	a_count_seen: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_in_q |-> (count_q == '0))
		else $error("cluster count without an in-range sample");

	// A clear result always carries the no-contact range.
	a_clear_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == STATUS_CLEAR)) |-> (range_mm_q == CLEAR_RANGE_MM))
		else $error("clear result with a wrong range");

	// The count never passes its cap.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(COUNT_CAP))
		else $error("cluster count above its cap");
`endif

endmodule

`default_nettype wire
